>>> src/gsb_pkg.sv
// Shared widths and register codes for the Gaussian pair source boost core.
// No dependencies.
`default_nettype none
package gsb_pkg;
  localparam int MOM_W      = 32;
  localparam int DEV_W      = 16;
  localparam int SIG_W      = 24;
  localparam int MEAN_W     = 25;
  localparam int RAD_W      = 28;
  localparam int ROUT_W     = 29;
  localparam int SQ_W       = 64;
  localparam int ROOT_W     = 32;
  localparam int PROD_W     = 62;
  localparam int NUM_W      = 96;
  localparam int DEN_W      = 64;
  localparam int QB         = 33;
  localparam int SEP_W      = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 25;

  localparam logic [CFG_IDX_W-1:0] CFG_SIGMA = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEAN  = 1'b1;

  typedef struct packed {
    logic signed [MOM_W-1:0]  px;
    logic signed [MOM_W-1:0]  py;
    logic signed [MOM_W-1:0]  pz;
    logic signed [MOM_W-1:0]  e;
    logic signed [ROUT_W-1:0] rout;
    logic signed [RAD_W-1:0]  rside;
    logic signed [RAD_W-1:0]  rlong;
    logic                     inv;
  } side_t;
endpackage
`default_nettype wire

>>> src/gsb_isqrt.sv
// Pipelined floor square root, one result bit per stage.
// Depends on gsb_pkg.
`default_nettype none
module gsb_isqrt (
  input  logic                       clk,
  input  logic                       en,
  input  logic [gsb_pkg::SQ_W-1:0]   x,
  output logic [gsb_pkg::ROOT_W-1:0] root
);
  import gsb_pkg::*;

  logic [SQ_W-1:0]   rem [1:ROOT_W-1];
  logic [ROOT_W-1:0] rt  [1:ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_st
    localparam int B = ROOT_W - 1 - k;
    logic [SQ_W-1:0]   rin;
    logic [SQ_W-1:0]   trial;
    logic [ROOT_W-1:0] qin;
    logic              take;
    if (k == 0) begin : g_first
      assign rin = x;
      assign qin = '0;
    end else begin : g_rest
      assign rin = rem[k];
      assign qin = rt[k];
    end
    assign trial = ({{(SQ_W-ROOT_W){1'b0}}, qin} << (B + 1)) | (SQ_W'(1) << (2 * B));
    assign take  = rin >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        rt[k+1] <= take ? (qin | (ROOT_W'(1) << B)) : qin;
      end
    end
    if (k < ROOT_W - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem[k+1] <= take ? rin - trial : rin;
        end
      end
    end
  end

  assign root = rt[ROOT_W];
endmodule
`default_nettype wire

>>> src/gsb_div.sv
// Pipelined signed divide by unsigned denominator, rounded half away from zero,
// saturated to 32 bits. Depends on gsb_pkg.
`default_nettype none
module gsb_div (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [gsb_pkg::NUM_W-1:0] num,
  input  logic [gsb_pkg::DEN_W-1:0]        den,
  output logic signed [gsb_pkg::SEP_W-1:0] quo
);
  import gsb_pkg::*;

  localparam int RW = NUM_W + 1;
  localparam logic [QB:0] QMAX = (QB+1)'((64'd1 << (SEP_W - 1)) - 64'd1);
  localparam logic [QB:0] QMIN = (QB+1)'(64'd1 << (SEP_W - 1));

  logic [NUM_W-1:0] rem [0:QB];
  logic [QB-1:0]    qt  [0:QB];
  logic [DEN_W-1:0] dv  [0:QB];
  logic             ng  [0:QB];
  logic             ov  [0:QB];
  logic [NUM_W-1:0] mag;
  logic [RW-1:0]    lim;

  assign mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign lim = {{(RW-DEN_W){1'b0}}, den} << QB;

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= mag;
      qt[0]  <= '0;
      dv[0]  <= den;
      ng[0]  <= num[NUM_W-1];
      ov[0]  <= {1'b0, mag} >= lim;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_st
    localparam int B = QB - 1 - k;
    logic [RW-1:0] trial;
    assign trial = {{(RW-DEN_W){1'b0}}, dv[k]} << B;
    always_ff @(posedge clk) begin
      if (en) begin
        if ({1'b0, rem[k]} >= trial) begin
          rem[k+1] <= rem[k] - trial[NUM_W-1:0];
          qt[k+1]  <= qt[k] | (QB'(1) << B);
        end else begin
          rem[k+1] <= rem[k];
          qt[k+1]  <= qt[k];
        end
        dv[k+1] <= dv[k];
        ng[k+1] <= ng[k];
        ov[k+1] <= ov[k];
      end
    end
  end

  logic          up;
  logic [QB:0]   qr;
  logic          sat;

  always_comb begin
    up  = {rem[QB][DEN_W-1:0], 1'b0} >= {1'b0, dv[QB]};
    qr  = {1'b0, qt[QB]} + (QB+1)'(up);
    sat = ov[QB] || (qr > (ng[QB] ? QMIN : QMAX));
    if (sat) begin
      quo = ng[QB] ? {1'b1, {(SEP_W-1){1'b0}}} : {1'b0, {(SEP_W-1){1'b1}}};
    end else begin
      quo = ng[QB] ? -$signed(qr[SEP_W-1:0]) : $signed(qr[SEP_W-1:0]);
    end
  end
endmodule
`default_nettype wire

>>> src/gaussian_source_pair_boost_core.sv
// Pipeline: 3 front stages, 32-stage square roots, 4 product stages, 34-stage
// dividers, output register.
// Throughput: one beat per cycle; the whole pipeline stalls only while the
// output register holds a beat that is not taken.
// Reset clears all valid bits and both configuration registers.
// Depends on gsb_pkg, gsb_isqrt, gsb_div.
`default_nettype none
module gaussian_source_pair_boost_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [gsb_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [gsb_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [gsb_pkg::MOM_W-1:0]      mom_x_a,
  input  logic signed [gsb_pkg::MOM_W-1:0]      mom_y_a,
  input  logic signed [gsb_pkg::MOM_W-1:0]      mom_z_a,
  input  logic signed [gsb_pkg::MOM_W-1:0]      energy_a,
  input  logic signed [gsb_pkg::MOM_W-1:0]      mom_x_b,
  input  logic signed [gsb_pkg::MOM_W-1:0]      mom_y_b,
  input  logic signed [gsb_pkg::MOM_W-1:0]      mom_z_b,
  input  logic signed [gsb_pkg::MOM_W-1:0]      energy_b,
  input  logic signed [gsb_pkg::DEV_W-1:0]      dev_out,
  input  logic signed [gsb_pkg::DEV_W-1:0]      dev_side,
  input  logic signed [gsb_pkg::DEV_W-1:0]      dev_long,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [gsb_pkg::SEP_W-1:0]      sep_x,
  output logic signed [gsb_pkg::SEP_W-1:0]      sep_y,
  output logic signed [gsb_pkg::SEP_W-1:0]      sep_z,
  output logic signed [gsb_pkg::SEP_W-1:0]      sep_time,
  output logic                                  kin_invalid
);
  import gsb_pkg::*;

  localparam int RAW_W = DEV_W + SIG_W + 1;
  localparam int NSQ   = ROOT_W;
  localparam int NDV   = QB + 1;

  logic                    en;
  logic [SIG_W-1:0]        sigma_width;
  logic signed [MEAN_W-1:0] out_mean;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      sigma_width <= '0;
      out_mean    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SIGMA: sigma_width <= cfg_data[SIG_W-1:0];
        CFG_MEAN:  out_mean    <= $signed(cfg_data[MEAN_W-1:0]);
        default: ;
      endcase
    end
  end

  function automatic logic signed [MOM_W-1:0] half_sum(input logic signed [MOM_W-1:0] a,
                                                       input logic signed [MOM_W-1:0] b);
    logic signed [MOM_W:0] s;
    s = (MOM_W+1)'(a) + (MOM_W+1)'(b);
    return $signed(s[MOM_W:1]);
  endfunction

  // stage 1: pair half-sums, deviate * sigma
  logic                    v1;
  logic signed [MOM_W-1:0] px1, py1, pz1, e1;
  logic signed [RAW_W-1:0] ro1, rs1, rl1;
  logic signed [RAW_W-1:0] sig_s;
  assign sig_s = RAW_W'($signed({1'b0, sigma_width}));

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px1 <= half_sum(mom_x_a, mom_x_b);
      py1 <= half_sum(mom_y_a, mom_y_b);
      pz1 <= half_sum(mom_z_a, mom_z_b);
      e1  <= half_sum(energy_a, energy_b);
      ro1 <= RAW_W'(dev_out) * sig_s;
      rs1 <= RAW_W'(dev_side) * sig_s;
      rl1 <= RAW_W'(dev_long) * sig_s;
    end
  end

  // stage 2: squares, radius rounding, mean added to the out radius
  function automatic logic signed [RAD_W-1:0] rnd16(input logic signed [RAW_W-1:0] v);
    logic signed [RAW_W-1:0] s;
    s = v + RAW_W'(2048);
    return $signed(s[RAD_W+11:12]);
  endfunction

  logic                     v2;
  logic signed [SQ_W-1:0]   sqe2, sqz2, sqx2, sqy2;
  logic signed [MOM_W-1:0]  px2, py2, pz2, e2;
  logic signed [ROUT_W-1:0] ro2;
  logic signed [RAD_W-1:0]  rs2, rl2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqe2 <= SQ_W'(e1) * SQ_W'(e1);
      sqz2 <= SQ_W'(pz1) * SQ_W'(pz1);
      sqx2 <= SQ_W'(px1) * SQ_W'(px1);
      sqy2 <= SQ_W'(py1) * SQ_W'(py1);
      px2  <= px1;
      py2  <= py1;
      pz2  <= pz1;
      e2   <= e1;
      ro2  <= ROUT_W'(rnd16(ro1)) + ROUT_W'(out_mean);
      rs2  <= rnd16(rs1);
      rl2  <= rnd16(rl1);
    end
  end

  // stage 3: mT^2, pT^2, M^2, kinematic check
  logic signed [SQ_W-1:0] mt2c;
  logic [SQ_W-1:0]        pt2c;
  logic                   v3;
  logic [SQ_W-1:0]        mt2_3, m2_3, pt2_3;
  side_t                  side3;

  assign mt2c = sqe2 - sqz2;
  assign pt2c = $unsigned(sqx2) + $unsigned(sqy2);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mt2_3       <= $unsigned(mt2c);
      pt2_3       <= pt2c;
      m2_3        <= $unsigned(mt2c) - pt2c;
      side3.px    <= px2;
      side3.py    <= py2;
      side3.pz    <= pz2;
      side3.e     <= e2;
      side3.rout  <= ro2;
      side3.rside <= rs2;
      side3.rlong <= rl2;
      side3.inv   <= (mt2c <= 0) || ($unsigned(mt2c) <= pt2c) || (pt2c == '0);
    end
  end

  // square roots
  logic [ROOT_W-1:0] rt_mt, rt_m, rt_pt;

  gsb_isqrt u_sqrt_mt (.clk(clk), .en(en), .x(mt2_3), .root(rt_mt));
  gsb_isqrt u_sqrt_m  (.clk(clk), .en(en), .x(m2_3),  .root(rt_m));
  gsb_isqrt u_sqrt_pt (.clk(clk), .en(en), .x(pt2_3), .root(rt_pt));

  side_t sd  [0:NSQ-1];
  logic  vsq [0:NSQ-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NSQ; i++) vsq[i] <= 1'b0;
    end else if (en) begin
      vsq[0] <= v3;
      for (int i = 1; i < NSQ; i++) vsq[i] <= vsq[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd[0] <= side3;
      for (int i = 1; i < NSQ; i++) sd[i] <= sd[i-1];
    end
  end

  // stage 4: first products and denominators
  side_t                    sq;
  logic signed [ROOT_W:0]   mt_s, m_s;
  logic                     v4, inv4;
  logic signed [PROD_W-1:0] pr4 [0:5];
  logic signed [MOM_W-1:0]  px4, py4;
  logic [ROOT_W-1:0]        pt4, m4;
  logic [DEN_W-1:0]         dxy4, dtz4;

  assign sq   = sd[NSQ-1];
  assign mt_s = $signed({1'b0, rt_mt});
  assign m_s  = $signed({1'b0, rt_m});

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= vsq[NSQ-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pr4[0] <= PROD_W'(sq.rout)  * PROD_W'(mt_s);
      pr4[1] <= PROD_W'(sq.rside) * PROD_W'(m_s);
      pr4[2] <= PROD_W'(sq.e)     * PROD_W'(sq.rout);
      pr4[3] <= PROD_W'(sq.pz)    * PROD_W'(sq.rlong);
      pr4[4] <= PROD_W'(sq.e)     * PROD_W'(sq.rlong);
      pr4[5] <= PROD_W'(sq.pz)    * PROD_W'(sq.rout);
      dxy4   <= DEN_W'(rt_m)  * DEN_W'(rt_pt);
      dtz4   <= DEN_W'(rt_mt) * DEN_W'(rt_m);
      px4    <= sq.px;
      py4    <= sq.py;
      pt4    <= rt_pt;
      m4     <= rt_m;
      inv4   <= sq.inv;
    end
  end

  // stage 5: second products as two partial products each
  logic signed [PROD_W-1:0] pm [0:7];
  logic signed [ROOT_W:0]   pv [0:7];
  logic signed [ROOT_W:0]   px4s, py4s, pt4s, m4s;
  logic                     v5, inv5;
  logic signed [SQ_W:0]     lo5 [0:7];
  logic signed [SQ_W-1:0]   hi5 [0:7];
  logic [DEN_W-1:0]         dxy5, dtz5;

  assign px4s = (ROOT_W+1)'(px4);
  assign py4s = (ROOT_W+1)'(py4);
  assign pt4s = $signed({1'b0, pt4});
  assign m4s  = $signed({1'b0, m4});

  assign pm[0] = pr4[0]; assign pv[0] = px4s;
  assign pm[1] = pr4[1]; assign pv[1] = py4s;
  assign pm[2] = pr4[0]; assign pv[2] = py4s;
  assign pm[3] = pr4[1]; assign pv[3] = px4s;
  assign pm[4] = pr4[2]; assign pv[4] = pt4s;
  assign pm[5] = pr4[3]; assign pv[5] = m4s;
  assign pm[6] = pr4[4]; assign pv[6] = m4s;
  assign pm[7] = pr4[5]; assign pv[7] = pt4s;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
  end

  for (genvar j = 0; j < 8; j++) begin : g_pp
    always_ff @(posedge clk) begin
      if (en) begin
        lo5[j] <= (SQ_W+1)'($signed({1'b0, pm[j][30:0]})) * (SQ_W+1)'(pv[j]);
        hi5[j] <= SQ_W'($signed(pm[j][PROD_W-1:31])) * SQ_W'(pv[j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dxy5 <= dxy4;
      dtz5 <= dtz4;
      inv5 <= inv4;
    end
  end

  // stage 6: combine partial products
  logic                    v6, inv6;
  logic signed [NUM_W-1:0] tm6 [0:7];
  logic [DEN_W-1:0]        dxy6, dtz6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= v5;
    end
  end

  for (genvar j = 0; j < 8; j++) begin : g_tm
    always_ff @(posedge clk) begin
      if (en) begin
        tm6[j] <= (NUM_W'(hi5[j]) <<< 31) + NUM_W'(lo5[j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dxy6 <= dxy5;
      dtz6 <= dtz5;
      inv6 <= inv5;
    end
  end

  // stage 7: numerators
  logic                    v7, inv7;
  logic signed [NUM_W-1:0] nx7, ny7, nt7, nz7;
  logic [DEN_W-1:0]        dxy7, dtz7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (en) begin
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nx7  <= tm6[0] - tm6[1];
      ny7  <= tm6[2] + tm6[3];
      nt7  <= tm6[4] + tm6[5];
      nz7  <= tm6[6] + tm6[7];
      dxy7 <= dxy6;
      dtz7 <= dtz6;
      inv7 <= inv6;
    end
  end

  // dividers
  logic signed [SEP_W-1:0] qx, qy, qt, qz;

  gsb_div u_div_x (.clk(clk), .en(en), .num(nx7), .den(dxy7), .quo(qx));
  gsb_div u_div_y (.clk(clk), .en(en), .num(ny7), .den(dxy7), .quo(qy));
  gsb_div u_div_t (.clk(clk), .en(en), .num(nt7), .den(dtz7), .quo(qt));
  gsb_div u_div_z (.clk(clk), .en(en), .num(nz7), .den(dtz7), .quo(qz));

  logic vdv [0:NDV-1];
  logic idv [0:NDV-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NDV; i++) vdv[i] <= 1'b0;
    end else if (en) begin
      vdv[0] <= v7;
      for (int i = 1; i < NDV; i++) vdv[i] <= vdv[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      idv[0] <= inv7;
      for (int i = 1; i < NDV; i++) idv[i] <= idv[i-1];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vdv[NDV-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sep_x       <= idv[NDV-1] ? '0 : qx;
      sep_y       <= idv[NDV-1] ? '0 : qy;
      sep_z       <= idv[NDV-1] ? '0 : qz;
      sep_time    <= idv[NDV-1] ? '0 : qt;
      kin_invalid <= idv[NDV-1];
    end
  end

  a_inv_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && kin_invalid |-> sep_x == 0 && sep_y == 0 && sep_z == 0 && sep_time == 0)
    else $error("invalid beat with nonzero separation");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  a_root_order: assert property (@(posedge clk) disable iff (rst)
    vsq[NSQ-1] && !sq.inv |-> rt_mt >= rt_m)
    else $error("mT root below M root");

  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    v5 && !inv5 |-> dxy5 != 0 && dtz5 != 0)
    else $error("zero denominator on valid kinematics");
endmodule
`default_nettype wire
